// ===== src/tilt_pkg.sv =====
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared types, constants and rotation helper for the tilt angle pipeline.
// ----------------------------------------------------------------------------
package tilt_pkg;

   // Number of micro-rotations in each angle chain (at most ATAN_ENTRIES)
   localparam int ANGLE_ITERATIONS = 16;
   localparam int ATAN_ENTRIES     = 25;

   // Square root: one result bit per cell
   localparam int SQRT_STEPS = 32;
   localparam int RAD_W      = 32;
   localparam int ROOT_W     = 32;
   localparam int REM_W      = 33;

   // Rotation datapath widths
   localparam int CORDIC_W = 44;
   localparam int ANGLE_W  = 33;
   localparam int IDX_W    = 5;

   // Angle constants in hundredths of a degree and in binary turn units
   localparam logic signed [15:0] CDEG_HALF    = 16'sd18000;
   localparam logic signed [15:0] CDEG_QUARTER = 16'sd9000;
   localparam logic signed [ANGLE_W-1:0] TURN_HALF = 33'sd2147483648;
   localparam logic [15:0] CDEG_PER_TURN = 16'd36000;

   // atan(2^-i) in units of 2^32 per full turn
   localparam logic signed [ANGLE_W-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      33'sd536870912, 33'sd316933406, 33'sd167458907, 33'sd85004756, 33'sd42667331,
      33'sd21354465,  33'sd10679838,  33'sd5340245,   33'sd2670163,  33'sd1335087,
      33'sd667544,    33'sd333772,    33'sd166886,    33'sd83443,    33'sd41722,
      33'sd20861,     33'sd10430,     33'sd5215,      33'sd2608,     33'sd1304,
      33'sd652,       33'sd326,       33'sd163,       33'sd81,       33'sd41
   };

   // Beat moving through the square root cells
   typedef struct packed {
      logic                vld;
      logic signed [15:0]  ax;
      logic signed [15:0]  ay;
      logic signed [15:0]  az;
      logic [RAD_W-1:0]    rad;
      logic [REM_W-1:0]    rem;
      logic [ROOT_W-1:0]   root;
   } sqrt_beat_type;

   // One atan2 lane
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ANGLE_W-1:0]  z;
      logic                       spec;
      logic signed [15:0]         spec_cdeg;
   } cordic_lane_type;

   // Beat moving through the rotation cells
   typedef struct packed {
      logic            vld;
      cordic_lane_type pitch;
      cordic_lane_type roll;
   } cordic_beat_type;

   // One vectoring micro-rotation toward y = 0
   function automatic cordic_lane_type cordic_rotate(input cordic_lane_type lane,
                                                     input logic [IDX_W-1:0] idx);
      cordic_lane_type            res;
      logic signed [CORDIC_W-1:0] xs;
      logic signed [CORDIC_W-1:0] ys;
      res = lane;
      xs  = lane.x >>> idx;
      ys  = lane.y >>> idx;
      if (!lane.y[CORDIC_W-1]) begin
         res.x = lane.x + ys;
         res.y = lane.y - xs;
         res.z = lane.z + ATAN_TABLE[idx];
      end else begin
         res.x = lane.x - ys;
         res.y = lane.y + xs;
         res.z = lane.z - ATAN_TABLE[idx];
      end
      return res;
   endfunction

endpackage

// ===== src/accel_tilt_angles_core.sv =====
// ----------------------------------------------------------------------------
// accel_tilt_angles_core
// Pitch and roll from one raw three-axis accelerometer sample.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample per beat: accel_x, accel_y, accel_z as raw
//   signed 16-bit counts. rsp_* returns one beat per sample with pitch and
//   roll in hundredths of a degree, in order.
//   An accepted request beat passes a square register and a sum register
//   (ax^2 + az^2), 32 root cells of one square root bit each, a setup
//   register for both atan2 lanes, ANGLE_ITERATIONS (16) rotation cells for
//   both lanes, then a scaling register and a rounding and clamping register.
//   Throughput is one sample per cycle while the output is not stalled; every
//   cell takes a new beat each cycle that the pipeline advances.
//   The pipeline advances whenever the output register is empty or being
//   taken. While the receiver holds rsp_tready low with a result waiting,
//   the whole chain holds and req_tready is low; nothing is lost.
//   Reset clears all valid bits; the block needs no warm-up after reset.
// ----------------------------------------------------------------------------
module accel_tilt_angles_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // accel_x[15:0], accel_y[31:16], accel_z[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // pitch_cdeg[14:0], roll_cdeg[30:15], zero[31]
);
   import tilt_pkg::*;

   typedef struct packed {
      logic               vld;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic [30:0]        ax2;
      logic [30:0]        az2;
   } square_type;

   logic               adv;
   square_type         sq_ff, sq_in;
   sqrt_beat_type      sum_ff, sum_in;
   sqrt_beat_type      sqrt_chain [SQRT_STEPS+1];
   cordic_beat_type    cordic_chain [ANGLE_ITERATIONS+1];
   cordic_beat_type    setup_ff, setup_in;
   logic signed [31:0] ax_sq;
   logic signed [31:0] az_sq;
   logic signed [16:0] neg_ax;
   logic signed [14:0] pitch_cdeg;
   logic signed [15:0] roll_cdeg;

   // Prepare one atan2 lane: special cases and the left half-plane fold
   function automatic cordic_lane_type lane_setup(input logic signed [CORDIC_W-1:0] y,
                                                  input logic signed [CORDIC_W-1:0] x);
      cordic_lane_type lane;
      lane.x         = x;
      lane.y         = y;
      lane.z         = '0;
      lane.spec      = 1'b0;
      lane.spec_cdeg = '0;
      if (y == '0) begin
         lane.spec      = 1'b1;
         lane.spec_cdeg = x[CORDIC_W-1] ? CDEG_HALF : 16'sd0;
      end else if (x == '0) begin
         lane.spec      = 1'b1;
         lane.spec_cdeg = y[CORDIC_W-1] ? -CDEG_QUARTER : CDEG_QUARTER;
      end else if (x[CORDIC_W-1]) begin
         lane.z = y[CORDIC_W-1] ? -TURN_HALF : TURN_HALF;
         lane.x = -x;
         lane.y = -y;
      end
      return lane;
   endfunction

   // Advance everything unless a result waits untaken
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // Square the horizontal axes
   always_comb begin
      az_sq     = $signed(req_tdata[47:32]) * $signed(req_tdata[47:32]);
      ax_sq     = $signed(req_tdata[15:0]) * $signed(req_tdata[15:0]);
      sq_in.vld = req_tvalid;
      sq_in.ax  = req_tdata[15:0];
      sq_in.ay  = req_tdata[31:16];
      sq_in.az  = req_tdata[47:32];
      sq_in.ax2 = ax_sq[30:0];
      sq_in.az2 = az_sq[30:0];
   end

   // Sum the squares and seed the root chain
   always_comb begin
      sum_in.vld  = sq_ff.vld;
      sum_in.ax   = sq_ff.ax;
      sum_in.ay   = sq_ff.ay;
      sum_in.az   = sq_ff.az;
      sum_in.rad  = {1'b0, sq_ff.ax2} + {1'b0, sq_ff.az2};
      sum_in.rem  = '0;
      sum_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff.vld  <= 1'b0;
         sum_ff.vld <= 1'b0;
      end else if (adv) begin
         sq_ff  <= sq_in;
         sum_ff <= sum_in;
      end
   end

   // Square root chain
   assign sqrt_chain[0] = sum_ff;

   for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
      tilt_sqrt_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_beat (sqrt_chain[i]),
         .dn_beat (sqrt_chain[i+1])
      );
   end

   // Set up both lanes: pitch from (ay, root), roll from (-ax, az)
   always_comb begin
      neg_ax         = -{sqrt_chain[SQRT_STEPS].ax[15], sqrt_chain[SQRT_STEPS].ax};
      setup_in.vld   = sqrt_chain[SQRT_STEPS].vld;
      setup_in.pitch = lane_setup(
         {{4{sqrt_chain[SQRT_STEPS].ay[15]}}, sqrt_chain[SQRT_STEPS].ay, 24'd0},
         {4'd0, sqrt_chain[SQRT_STEPS].root, 8'd0});
      setup_in.roll  = lane_setup(
         {{3{neg_ax[16]}}, neg_ax, 24'd0},
         {{4{sqrt_chain[SQRT_STEPS].az[15]}}, sqrt_chain[SQRT_STEPS].az, 24'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setup_ff.vld <= 1'b0;
      end else if (adv) begin
         setup_ff <= setup_in;
      end
   end

   // Rotation chain
   assign cordic_chain[0] = setup_ff;

   for (genvar i = 0; i < ANGLE_ITERATIONS; i++) begin : g_cordic
      tilt_cordic_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .step_idx (IDX_W'(i)),
         .up_beat  (cordic_chain[i]),
         .dn_beat  (cordic_chain[i+1])
      );
   end

   // Scale, round, clamp and hold the result beat
   tilt_angle_out u_out (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .up_beat    (cordic_chain[ANGLE_ITERATIONS]),
      .out_vld    (rsp_tvalid),
      .pitch_cdeg (pitch_cdeg),
      .roll_cdeg  (roll_cdeg)
   );

   assign rsp_tdata = {1'b0, roll_cdeg, pitch_cdeg};

`ifndef ASSERT_OFF
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (pitch_cdeg >= -15'(CDEG_QUARTER) && pitch_cdeg <= 15'(CDEG_QUARTER)))
      else $error("pitch outside quarter turn");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (roll_cdeg > -CDEG_HALF && roll_cdeg <= CDEG_HALF))
      else $error("roll outside half-open half turn");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(setup_ff) && $stable(sum_ff))
      else $error("pipeline moved while stalled");
`endif

endmodule

// ===== src/tilt_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// tilt_sqrt_cell
// One digit step of the restoring integer square root.
// ----------------------------------------------------------------------------
module tilt_sqrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  tilt_pkg::sqrt_beat_type up_beat,
   output tilt_pkg::sqrt_beat_type dn_beat
);
   import tilt_pkg::*;

   sqrt_beat_type      beat_ff;
   sqrt_beat_type      beat_in;
   logic [REM_W+1:0]   rem_sh;
   logic [REM_W+1:0]   trial;
   logic [REM_W+1:0]   diff;
   logic               take;

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      rem_sh  = {up_beat.rem, up_beat.rad[RAD_W-1 -: 2]};
      trial   = {1'b0, up_beat.root, 2'b01};
      diff    = rem_sh - trial;
      take    = (rem_sh >= trial);
      beat_in = up_beat;
      beat_in.rad  = {up_beat.rad[RAD_W-3:0], 2'b00};
      beat_in.rem  = take ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      beat_in.root = {up_beat.root[ROOT_W-2:0], take};
   end

   // Advance the beat to the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.vld <= 1'b0;
      end else if (adv) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_beat = beat_ff;

endmodule

// ===== src/tilt_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// tilt_cordic_cell
// One micro-rotation for both the pitch and the roll lane.
// ----------------------------------------------------------------------------
module tilt_cordic_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [tilt_pkg::IDX_W-1:0] step_idx,
   input  tilt_pkg::cordic_beat_type  up_beat,
   output tilt_pkg::cordic_beat_type  dn_beat
);
   import tilt_pkg::*;

   cordic_beat_type beat_ff;
   cordic_beat_type beat_in;

   // Rotate both lanes by this cell's fixed angle
   always_comb begin
      beat_in       = up_beat;
      beat_in.pitch = cordic_rotate(up_beat.pitch, step_idx);
      beat_in.roll  = cordic_rotate(up_beat.roll, step_idx);
   end

   // Advance the beat to the neighbor
   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.vld <= 1'b0;
      end else if (adv) begin
         beat_ff <= beat_in;
      end
   end

   assign dn_beat = beat_ff;

endmodule

// ===== src/tilt_angle_out.sv =====
// ----------------------------------------------------------------------------
// tilt_angle_out
// Scale turn units to hundredths of a degree, round, clamp and hold result.
// ----------------------------------------------------------------------------
module tilt_angle_out (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  tilt_pkg::cordic_beat_type up_beat,
   output logic                      out_vld,
   output logic signed [14:0]        pitch_cdeg,
   output logic signed [15:0]        roll_cdeg
);
   import tilt_pkg::*;

   typedef struct packed {
      logic [47:0]        prod;
      logic               neg;
      logic               spec;
      logic signed [15:0] spec_cdeg;
   } scaled_type;

   logic                vld1_ff;
   scaled_type          pitch1_ff, pitch1_in;
   scaled_type          roll1_ff, roll1_in;
   logic                vld2_ff;
   logic signed [14:0]  pitch2_ff, pitch2_in;
   logic signed [15:0]  roll2_ff, roll2_in;
   logic signed [16:0]  pitch_a;
   logic signed [16:0]  roll_a;

   function automatic scaled_type scale_lane(input cordic_lane_type lane);
      scaled_type                res;
      logic signed [ANGLE_W-1:0] mag;
      mag           = lane.z[ANGLE_W-1] ? -lane.z : lane.z;
      res.prod      = mag[31:0] * CDEG_PER_TURN;
      res.neg       = lane.z[ANGLE_W-1];
      res.spec      = lane.spec;
      res.spec_cdeg = lane.spec_cdeg;
      return res;
   endfunction

   function automatic logic signed [16:0] round_lane(input scaled_type s);
      logic [47:0]        rsum;
      logic signed [16:0] mag;
      rsum = s.prod + 48'h0000_8000_0000;
      mag  = {1'b0, rsum[47:32]};
      if (s.spec) begin
         return {s.spec_cdeg[15], s.spec_cdeg};
      end
      return s.neg ? -mag : mag;
   endfunction

   // Scale magnitudes by hundredths of a degree per turn
   always_comb begin
      pitch1_in = scale_lane(up_beat.pitch);
      roll1_in  = scale_lane(up_beat.roll);
   end

   // Round, restore sign, clamp pitch and fold roll onto (-18000, 18000]
   always_comb begin
      pitch_a = round_lane(pitch1_ff);
      roll_a  = round_lane(roll1_ff);
      if (pitch_a > 17'(CDEG_QUARTER)) begin
         pitch2_in = 15'(CDEG_QUARTER);
      end else if (pitch_a < -17'(CDEG_QUARTER)) begin
         pitch2_in = -15'(CDEG_QUARTER);
      end else begin
         pitch2_in = pitch_a[14:0];
      end
      if (roll_a > 17'(CDEG_HALF) || roll_a <= -17'(CDEG_HALF)) begin
         roll2_in = CDEG_HALF;
      end else begin
         roll2_in = roll_a[15:0];
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= up_beat.vld;
         vld2_ff <= vld1_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         pitch1_ff <= pitch1_in;
         roll1_ff  <= roll1_in;
         pitch2_ff <= pitch2_in;
         roll2_ff  <= roll2_in;
      end
   end

   assign out_vld    = vld2_ff;
   assign pitch_cdeg = pitch2_ff;
   assign roll_cdeg  = roll2_ff;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for accel_tilt_angles_core: drives raw accelerometer
// samples on req_*, predicts pitch and roll with an independent integer
// square root and CORDIC vectoring model, and checks every rsp_* beat in
// order under several sender idle and receiver stall mixes.
// ----------------------------------------------------------------------------
class tilt_angle_board;

   typedef struct packed {
      logic signed [14:0] pitch;
      logic signed [15:0] roll;
   } tilt_angles_type;

   localparam int      ROT_STEPS  = 16;
   localparam longint  HALF_TURN  = 64'sd2147483648;

   // atan(2^-i) in units of 2^32 per full turn
   static const longint arc_step [25] = '{
      536870912, 316933406, 167458907, 85004756, 42667331,
      21354465,  10679838,  5340245,   2670163,  1335087,
      667544,    333772,    166886,    83443,    41722,
      20861,     10430,     5215,      2608,     1304,
      652,       326,       163,       81,       41
   };

   tilt_angles_type expected_angles [$];
   int              mismatches;

   function new();
      mismatches = 0;
   endfunction

   // Exact floor square root of a 64-bit value
   function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      res  = 0;
      bitv = 64'h4000_0000_0000_0000;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n   -= res + bitv;
            res  = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // atan2(y, x) in hundredths of a degree, rounded half away from zero
   function longint vector_angle(longint y, longint x);
      longint          z;
      longint          xs;
      longint          ys;
      longint unsigned mag;
      longint          r;
      if (y == 0) return (x < 0) ? 18000 : 0;
      if (x == 0) return (y > 0) ? 9000 : -9000;
      z = 0;
      // fold the left half plane onto the right one
      if (x < 0) begin
         z = (y > 0) ? HALF_TURN : -HALF_TURN;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys;
            y -= xs;
            z += arc_step[i];
         end else begin
            x -= ys;
            y += xs;
            z -= arc_step[i];
         end
      end
      mag = (z < 0) ? -z : z;
      r   = longint'((mag * 64'd36000 + 64'd2147483648) >> 32);
      return (z < 0) ? -r : r;
   endfunction

   function tilt_angles_type predict_angles(logic [47:0] beat);
      tilt_angles_type res;
      longint          ax;
      longint          ay;
      longint          az;
      longint unsigned sum;
      longint          root;
      longint          pitch;
      longint          roll;
      ax    = longint'($signed(beat[15:0]));
      ay    = longint'($signed(beat[31:16]));
      az    = longint'($signed(beat[47:32]));
      sum   = longint'(ax * ax + az * az);
      root  = longint'(int_sqrt(sum << 32));
      pitch = vector_angle(ay * 16777216, root * 256);
      roll  = vector_angle(-ax * 16777216, az * 16777216);
      if (pitch > 9000)   pitch = 9000;
      if (pitch < -9000)  pitch = -9000;
      if (roll > 18000)   roll = 18000;
      if (roll <= -18000) roll = 18000;
      res.pitch = pitch[14:0];
      res.roll  = roll[15:0];
      return res;
   endfunction

   function void note_sample(logic [47:0] beat);
      expected_angles.push_back(predict_angles(beat));
   endfunction

   function int pending();
      return expected_angles.size();
   endfunction

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
   endtask

   task check_result(logic [31:0] beat);
      tilt_angles_type want;
      if (expected_angles.size() == 0) begin
         report_mismatch($sformatf("unexpected result beat %h", beat));
         return;
      end
      want = expected_angles.pop_front();
      if (beat[14:0] !== want.pitch || beat[30:15] !== want.roll || beat[31] !== 1'b0)
         report_mismatch($sformatf("pitch %0d roll %0d pad %b, want pitch %0d roll %0d",
                                   $signed(beat[14:0]), $signed(beat[30:15]), beat[31],
                                   want.pitch, want.roll));
   endtask

endclass

module testbench;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 80;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int cycle_count = 0;

   tilt_angle_board board = new();

   accel_tilt_angles_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Stall the result side at the current rate
   always @(posedge clock) begin
      rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
   end

   // Record accepted samples and check result beats
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) board.note_sample(req_tdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[accel_tilt_angles_core] ERROR");
         $finish;
      end
   end

   // Present one sample, with random idle cycles ahead of it
   task automatic send_sample(input logic signed [15:0] ax, input logic signed [15:0] ay,
                              input logic signed [15:0] az);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {az, ay, ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold off the sender until every expected result has come
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // Draw one axis value from a mix of full range, small, zero and edge values
   function automatic logic signed [15:0] pick_axis(int mode);
      logic signed [15:0] edges [6] = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0,
                                        16'sd1, 16'sd32767};
      case (mode)
         0: return 16'($urandom);
         1: return $signed(16'($urandom_range(128))) - 16'sd64;
         2: return ($urandom_range(3) == 0) ? 16'sd0 : 16'($urandom);
         default: return edges[$urandom_range(5)];
      endcase
   endfunction

   task automatic run_random(input int count);
      int mode;
      repeat (count) begin
         mode = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 3);
         send_sample(pick_axis(mode), pick_axis(mode), pick_axis(mode));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: zeros, extremes, axis-aligned and half-turn cases
      send_sample(16'sd0, 16'sd0, 16'sd0);
      send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
      send_sample(16'sd32767, 16'sd32767, 16'sd32767);
      send_sample(16'sd0, 16'sd0, -16'sd100);
      send_sample(16'sd0, 16'sd0, -16'sd32768);
      send_sample(16'sd0, 16'sd0, 16'sd16384);
      send_sample(16'sd1000, 16'sd0, 16'sd0);
      send_sample(-16'sd1000, 16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd32767, 16'sd0);
      send_sample(16'sd0, -16'sd32768, 16'sd0);
      send_sample(16'sd1, 16'sd0, -16'sd32768);
      send_sample(-16'sd1, 16'sd0, -16'sd32768);
      send_sample(16'sd32767, -16'sd32768, -16'sd32768);
      send_sample(-16'sd32768, 16'sd32767, 16'sd1);
      send_sample(16'sd1, 16'sd1, 16'sd1);
      send_sample(-16'sd1, -16'sd1, -16'sd1);
      send_sample(16'sd1, -16'sd32768, 16'sd0);
      send_sample(16'sd0, 16'sd1, 16'sd0);
      send_sample(16'sd8192, 16'sd8192, 16'sd8192);
      send_sample(-16'sd12345, 16'sd4321, -16'sd2000);
      drain_results();

      // Random phases: no idling, sender idle, receiver stall, both
      run_random(125);
      send_idle_pct = 78;
      run_random(125);
      drain_results();
      send_idle_pct = 0;
      recv_stall_pct = 78;
      run_random(125);
      send_idle_pct = 37;
      recv_stall_pct = 37;
      run_random(125);

      drain_results();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("[accel_tilt_angles_core] OK");
      end else begin
         $display("[accel_tilt_angles_core] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/tilt_pkg.sv
src/tilt_sqrt_cell.sv
src/tilt_cordic_cell.sv
src/tilt_angle_out.sv
src/accel_tilt_angles_core.sv
tb/testbench.sv
